@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL files. Each expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

@@ rtl/xvtt_pkg.sv @@
package xvtt_pkg;

	localparam int INDEX_BITS_DEFAULT = 16;

	localparam int HASH_W  = 64;
	localparam int MOVE_W  = 16;
	localparam int SCORE_W = 16;
	localparam int DEPTH_W = 8;
	localparam int BOUND_W = 8;
	localparam int AGE_W   = 8;
	localparam int CNT_W   = 32;

	// Payload layout from bit 0: move, score, depth, bound, age.
	localparam int PAY_W  = MOVE_W + SCORE_W + DEPTH_W + BOUND_W + AGE_W;
	localparam int SLOT_W = HASH_W + PAY_W;

	localparam int IN_FIELDS_W  = HASH_W + MOVE_W + SCORE_W + DEPTH_W + BOUND_W;
	localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = 2 + PAY_W + 2 * CNT_W;
	localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

	typedef enum logic {
		OP_PROBE = 1'b0,
		OP_STORE = 1'b1
	} xvtt_op_t;

	// Controller to datapath.
	typedef struct packed {
		logic clear;
		logic accept;
		logic commit;
	} xvtt_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic clear_last;
		logic out_busy;
	} xvtt_status_t;

endpackage

@@ rtl/xvtt_ctrl.sv @@
`include "assert_macros.svh"

module xvtt_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  xvtt_pkg::xvtt_status_t st,
	output xvtt_pkg::xvtt_cmd_t    cmd
);
	import xvtt_pkg::*;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP
	} state_t;

	state_t state_q;
	logic   ready_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			ready_q <= 1'b0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					if (st.clear_last) begin
						state_q <= ST_IDLE;
						ready_q <= 1'b1;
					end
				end
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						state_q <= ST_LOOKUP;
						ready_q <= 1'b0;
					end
				end
				ST_LOOKUP: begin
					// Wait here while the previous result is still unclaimed.
					if (!st.out_busy) begin
						state_q <= ST_IDLE;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
					ready_q <= 1'b0;
				end
			endcase
		end
	end

	assign s_axis_tready = ready_q;

	always_comb begin
		cmd.clear  = (state_q == ST_CLEAR);
		cmd.accept = ready_q && s_axis_tvalid;
		cmd.commit = (state_q == ST_LOOKUP) && !st.out_busy;
	end

	`ASSERT_NEXT(a_accept_then_lookup, cmd.accept, state_q == ST_LOOKUP && !ready_q)
	`ASSERT_SAME(a_no_accept_in_clear, cmd.clear, !ready_q && !cmd.commit)

endmodule

@@ rtl/xvtt_datapath.sv @@
`include "assert_macros.svh"

module xvtt_datapath #(
	parameter int INDEX_BITS = xvtt_pkg::INDEX_BITS_DEFAULT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [xvtt_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	input  logic                            s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [xvtt_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input  logic                            cfg_wr_en,
	input  logic [xvtt_pkg::AGE_W-1:0]      cfg_wr_data,
	input  xvtt_pkg::xvtt_cmd_t             cmd,
	output xvtt_pkg::xvtt_status_t          st
);
	import xvtt_pkg::*;

	localparam int DEPTH = 1 << INDEX_BITS;

	// Each slot holds {payload, key ^ payload}.
	logic [SLOT_W-1:0] mem [DEPTH];

	logic [SLOT_W-1:0]     rd_q;
	logic [INDEX_BITS-1:0] clr_cnt_q;
	logic [AGE_W-1:0]      gen_q;
	xvtt_op_t              op_q;
	logic [HASH_W-1:0]     hash_q;
	logic [MOVE_W-1:0]     move_q;
	logic [SCORE_W-1:0]    score_q;
	logic [DEPTH_W-1:0]    depth_q;
	logic [BOUND_W-1:0]    bound_q;
	logic [CNT_W-1:0]      hits_q;
	logic [CNT_W-1:0]      misses_q;
	logic                  m_valid_q;
	logic [OUT_DATA_W-1:0] m_data_q;

	logic [PAY_W-1:0]      pay;
	logic [HASH_W-1:0]     stored_key;
	logic                  key_match;
	logic                  probe_hit;
	logic                  store_write;
	logic                  is_probe;
	logic [PAY_W-1:0]      new_pay;
	logic [SLOT_W-1:0]     new_slot;
	logic [CNT_W-1:0]      hits_nx;
	logic [CNT_W-1:0]      misses_nx;
	logic                  wr_en;
	logic [INDEX_BITS-1:0] wr_addr;
	logic [SLOT_W-1:0]     wr_data;
	logic [OUT_FIELDS_W-1:0] out_fields;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q <= '0;
		end else if (cfg_wr_en) begin
			gen_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q    <= xvtt_op_t'(s_axis_tuser);
			hash_q  <= s_axis_tdata[HASH_W-1:0];
			move_q  <= s_axis_tdata[HASH_W +: MOVE_W];
			score_q <= s_axis_tdata[HASH_W+MOVE_W +: SCORE_W];
			depth_q <= s_axis_tdata[HASH_W+MOVE_W+SCORE_W +: DEPTH_W];
			bound_q <= s_axis_tdata[HASH_W+MOVE_W+SCORE_W+DEPTH_W +: BOUND_W];
		end
	end

	always_comb begin
		pay        = rd_q[SLOT_W-1:HASH_W];
		stored_key = rd_q[HASH_W-1:0] ^ {{(HASH_W-PAY_W){1'b0}}, pay};
		key_match  = (stored_key == hash_q);
		is_probe   = (op_q == OP_PROBE);
		probe_hit  = key_match && (pay[PAY_W-AGE_W-1 -: BOUND_W] != '0);
		// Replace on same key, on a stale entry, or on equal or greater depth.
		store_write = key_match || (pay[PAY_W-1 -: AGE_W] != gen_q) ||
			($signed(depth_q) >= $signed(pay[MOVE_W+SCORE_W +: DEPTH_W]));
		new_pay  = {gen_q, bound_q, depth_q, score_q, move_q};
		new_slot = {new_pay, hash_q ^ {{(HASH_W-PAY_W){1'b0}}, new_pay}};
		hits_nx   = hits_q + CNT_W'(is_probe && probe_hit);
		misses_nx = misses_q + CNT_W'(is_probe && !probe_hit);
		out_fields = {misses_nx, hits_nx,
			(is_probe && probe_hit) ? pay : {PAY_W{1'b0}},
			!is_probe && store_write, is_probe && probe_hit};
	end

	always_comb begin
		wr_en   = cmd.clear || (cmd.commit && !is_probe && store_write);
		wr_addr = cmd.clear ? clr_cnt_q : hash_q[INDEX_BITS-1:0];
		wr_data = cmd.clear ? {SLOT_W{1'b0}} : new_slot;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.accept) begin
			rd_q <= mem[s_axis_tdata[INDEX_BITS-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clear) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hits_q    <= '0;
			misses_q  <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				hits_q    <= hits_nx;
				misses_q  <= misses_nx;
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			m_data_q <= {{(OUT_DATA_W-OUT_FIELDS_W){1'b0}}, out_fields};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	always_comb begin
		st.clear_last = &clr_cnt_q;
		st.out_busy   = m_valid_q && !m_axis_tready;
	end

	`ASSERT_NEXT(a_commit_shows_result, cmd.commit, m_valid_q)
	`ASSERT_NEXT(a_probe_counts_once, cmd.commit && is_probe,
		(hits_q - $past(hits_q)) + (misses_q - $past(misses_q)) == 32'd1)

endmodule

@@ rtl/xor_validated_transposition_table_unit.sv @@
// Direct-mapped transposition table with XOR-validated slots. After reset the
// unit clears all 2^INDEX_BITS slots, one per cycle (65536 slots at the default
// size); s_axis_tready stays low during that pass, while generation writes are
// taken. After that each transaction's slot is read from the synchronous slot
// memory into a register on acceptance; the lookup state then checks the key,
// decides replacement, writes the slot back and loads the output register. A
// result not taken stalls the next lookup until taken; the next transaction may
// be accepted while the previous result is still waiting. Every transaction, probe
// or store, returns exactly one result carrying the running hit and miss counts.
module xor_validated_transposition_table_unit #(
	parameter int INDEX_BITS = xvtt_pkg::INDEX_BITS_DEFAULT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// hash[63:0], move_in[79:64], score_in[95:80], depth_in[103:96], bound_in[111:104]
	input  logic [xvtt_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// opcode[0]: 0 probe, 1 store
	input  logic                            s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// hit[0], replaced[1], move_out[17:2], score_out[33:18], depth_out[41:34],
	// bound_out[49:42], age_out[57:50], hits_total[89:58], misses_total[121:90]
	output logic [xvtt_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input  logic                            cfg_wr_en,
	input  logic [xvtt_pkg::AGE_W-1:0]      cfg_wr_data
);
	import xvtt_pkg::*;

	xvtt_cmd_t    cmd;
	xvtt_status_t st;

	xvtt_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.st            (st),
		.cmd           (cmd)
	);

	xvtt_datapath #(
		.INDEX_BITS (INDEX_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.cmd           (cmd),
		.st            (st)
	);

endmodule
